/* rtl/upr_pkg.sv */
// Package for the ultrasonic ping ranger: field widths, register indexes,
// reset values and the result flag struct. No dependencies.
`timescale 1ns / 1ps

package upr_pkg;

    localparam int FRACTION_BITS_DEF = 4;
    localparam int DIVISOR_DEF       = 58;

    localparam int IDX_W  = 15;
    localparam int TICK_W = 16;
    localparam int DIST_W = 14;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;

    localparam logic [ADDR_W-1:0] CFG_TRIGGER = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_HOLDOFF = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_WINDOW  = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_MIN_END = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_SETTLE  = 3'd4;

    localparam logic [7:0]        TRIGGER_RST = 8'd5;
    localparam logic [15:0]       HOLDOFF_RST = 16'd750;
    localparam logic [IDX_W-1:0]  WINDOW_RST  = 15'd18500;
    localparam logic [IDX_W-1:0]  MIN_END_RST = 15'd115;
    localparam logic [15:0]       SETTLE_RST  = 16'd10000;

    typedef struct packed {
        logic tmo;
        logic done;
        logic busy;
        logic drv_lvl;
        logic drv_en;
    } t_upr_flags;

endpackage

/* rtl/ultrasonic_ping_ranger_core.sv */
// Top level of the ultrasonic ping ranger: tick-driven phase sequencer with a
// two-stage result pipeline. Depends on upr_pkg and upr_dist_scale.
`timescale 1ns / 1ps

// One request in is one microsecond tick; each tick gives exactly one result
// request out, two stages later, and a new tick is taken every cycle while the
// output side keeps up. The sequencer updates its phase and counters in the
// cycle a tick is taken; the distance divide (one reciprocal multiply) runs in
// the second stage. Distance is held between measurements and reads 0 with
// timed_out set when the echo window expires.

module ultrasonic_ping_ranger_core
    import upr_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int DIVISOR       = DIVISOR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // start_req, echo_level
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // pin_drive_enable, pin_drive_level, busy_res,
                                         // done_res, timed_out, distance_cm_q4
);

    localparam int NUM_W = IDX_W + FRACTION_BITS;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TRIG   = 3'd1;
    localparam logic [2:0] PH_HOLD   = 3'd2;
    localparam logic [2:0] PH_SAMPLE = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;

    logic [7:0]        r_trigger;
    logic [15:0]       r_holdoff;
    logic [IDX_W-1:0]  r_window;
    logic [IDX_W-1:0]  r_min_end;
    logic [15:0]       r_settle;

    logic [2:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [IDX_W-1:0]  r_fhi, n_fhi;

    logic              r_a_valid;
    t_upr_flags        r_a_flags, n_a_flags;
    logic [NUM_W-1:0]  r_a_num, n_a_num;

    logic              r_b_valid;
    t_upr_flags        r_b_flags;
    logic [DIST_W-1:0] r_b_dist;
    logic [DIST_W-1:0] scaled;

    logic s_fire;
    logic a_adv;

    assign a_adv    = !r_b_valid || m_tready;
    assign s_tready = !r_a_valid || a_adv;
    assign s_fire   = s_tvalid && s_tready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger <= TRIGGER_RST;
            r_holdoff <= HOLDOFF_RST;
            r_window  <= WINDOW_RST;
            r_min_end <= MIN_END_RST;
            r_settle  <= SETTLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TRIGGER: r_trigger <= i_cfg_wdata[7:0];
                CFG_HOLDOFF: r_holdoff <= i_cfg_wdata;
                CFG_WINDOW:  r_window  <= i_cfg_wdata[IDX_W-1:0];
                CFG_MIN_END: r_min_end <= i_cfg_wdata[IDX_W-1:0];
                CFG_SETTLE:  r_settle  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        logic              v_start;
        logic              v_echo;
        logic [2:0]        v_ph;
        logic [TICK_W-1:0] v_tick;
        logic [TICK_W-1:0] v_inc;
        logic [IDX_W-1:0]  v_fhi;
        logic [IDX_W-1:0]  v_idx;
        logic [IDX_W-1:0]  v_dur;
        logic [2:0]        v_after;

        v_start = s_tdata[0];
        v_echo  = s_tdata[1];
        v_ph    = r_phase;
        v_tick  = r_tick;
        v_fhi   = r_fhi;
        if (r_phase == PH_IDLE && v_start) begin
            v_ph   = PH_TRIG;
            v_tick = '0;
            v_fhi  = '0;
        end
        v_inc   = v_tick + TICK_W'(1);
        v_idx   = v_tick[IDX_W-1:0];
        v_dur   = (v_idx >= v_fhi) ? (v_idx - v_fhi) : '0;
        v_after = (r_settle == 16'd0) ? PH_IDLE : PH_SETTLE;

        n_phase   = v_ph;
        n_tick    = v_tick;
        n_fhi     = v_fhi;
        n_a_flags = '0;
        n_a_num   = '0;

        unique case (v_ph)
            PH_TRIG: begin
                n_a_flags.drv_en  = 1'b1;
                n_a_flags.drv_lvl = 1'b1;
                n_a_flags.busy    = 1'b1;
                n_tick = v_inc;
                if (v_inc >= TICK_W'(r_trigger)) begin
                    n_tick  = '0;
                    n_phase = (r_holdoff == 16'd0) ? PH_SAMPLE : PH_HOLD;
                end
            end
            PH_HOLD: begin
                n_a_flags.drv_en = 1'b1;
                n_a_flags.busy   = 1'b1;
                n_tick = v_inc;
                if (v_inc >= r_holdoff) begin
                    n_tick  = '0;
                    n_phase = PH_SAMPLE;
                end
            end
            PH_SAMPLE: begin
                n_a_flags.busy = 1'b1;
                if (v_echo && v_fhi == '0) begin
                    n_fhi = v_idx;
                end
                if (!v_echo && v_idx > r_min_end) begin
                    n_a_flags.done = 1'b1;
                    n_a_num = NUM_W'(v_dur) << FRACTION_BITS;
                    n_tick  = '0;
                    n_phase = v_after;
                end else begin
                    n_tick = v_inc;
                    if (v_inc >= TICK_W'(r_window)) begin
                        n_a_flags.done = 1'b1;
                        n_a_flags.tmo  = 1'b1;
                        n_tick  = '0;
                        n_phase = v_after;
                    end
                end
            end
            PH_SETTLE: begin
                n_a_flags.busy = 1'b1;
                n_tick = v_inc;
                if (v_inc >= r_settle) begin
                    n_tick  = '0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_fhi     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_fhi   <= n_fhi;
            end
            if (s_tready) begin
                r_a_valid <= s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_flags <= n_a_flags;
            r_a_num   <= n_a_num;
        end
    end

    // distance stage
    upr_dist_scale #(
        .FRACTION_BITS (FRACTION_BITS),
        .DIVISOR       (DIVISOR)
    ) u_scale (
        .i_num  (r_a_num),
        .o_dist (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_dist  <= '0;
        end else if (a_adv) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid && r_a_flags.done) begin
                r_b_dist <= scaled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_valid) begin
            r_b_flags <= r_a_flags;
        end
    end

    assign m_tvalid = r_b_valid;
    assign m_tdata  = {5'b0, r_b_dist, r_b_flags.tmo, r_b_flags.done,
                       r_b_flags.busy, r_b_flags.drv_lvl, r_b_flags.drv_en};

endmodule

/* rtl/upr_dist_scale.sv */
// Echo duration to distance: divide by a constant through an exact reciprocal
// multiply, then saturate to the 14-bit field. Depends on upr_pkg.
`timescale 1ns / 1ps

module upr_dist_scale
    import upr_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int DIVISOR       = DIVISOR_DEF
) (
    input  logic [IDX_W+FRACTION_BITS-1:0] i_num,
    output logic [DIST_W-1:0]              o_dist
);

    localparam int NUM_W = IDX_W + FRACTION_BITS;
    localparam int SH    = NUM_W + 8;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [SH:0] RECIP = RECIP_FULL[SH:0];

    logic [NUM_W+SH:0] prod;
    logic [NUM_W-1:0]  quot;

    assign prod = (NUM_W+SH+1)'(i_num) * (NUM_W+SH+1)'(RECIP);
    assign quot = prod[SH +: NUM_W];

    always_comb begin
        if (quot > NUM_W'(DIST_MAX)) begin
            o_dist = DIST_MAX;
        end else begin
            o_dist = quot[DIST_W-1:0];
        end
    end

endmodule

/* tb/upr_tick_checker.sv */
// Checker for the ultrasonic ping ranger: watches the register port and both streams,
// predicts the result of every accepted tick and compares it. Depends on upr_pkg.
`timescale 1ns / 1ps

module upr_tick_checker
    import upr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [7:0]        i_s_tdata,   // start_req, echo_level
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [23:0]       i_m_tdata,   // pin_drive_enable, pin_drive_level, busy_res,
                                           // done_res, timed_out, distance_cm_q4
    output int                o_fail_count,
    output int                o_pending,
    output int                o_done_count,
    output int                o_timeout_count
);

    typedef enum logic [2:0] {
        RNG_IDLE,
        RNG_TRIG,
        RNG_HOLD,
        RNG_SAMPLE,
        RNG_SETTLE
    } t_rng_phase;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        t_upr_flags        flags;
    } t_tick_result;

    logic [7:0]        trig_cfg;
    logic [15:0]       hold_cfg;
    logic [IDX_W-1:0]  win_cfg;
    logic [IDX_W-1:0]  mend_cfg;
    logic [15:0]       settle_cfg;

    t_rng_phase        phase;
    logic [TICK_W-1:0] tick_cnt;
    logic [IDX_W-1:0]  first_hi;
    logic [DIST_W-1:0] last_dist;
    logic              last_tmo;

    t_tick_result      results_due[$];

    task automatic finish_measurement(input logic [DIST_W-1:0] distance, input logic tmo);
        last_dist = distance;
        last_tmo  = tmo;
        tick_cnt  = '0;
        phase     = (settle_cfg == 0) ? RNG_IDLE : RNG_SETTLE;
    endtask

    task automatic predict_tick(input logic start, input logic echo, output t_tick_result res);
        logic [IDX_W-1:0] idx;
        int unsigned      dur;
        int unsigned      quot;
        logic             tmo;
        res = '0;
        tmo = 1'b0;
        if (phase == RNG_IDLE && start) begin
            phase    = RNG_TRIG;
            tick_cnt = '0;
            first_hi = '0;
        end
        case (phase)
            RNG_TRIG: begin
                res.flags.drv_en  = 1'b1;
                res.flags.drv_lvl = 1'b1;
                res.flags.busy    = 1'b1;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= trig_cfg) begin
                    tick_cnt = '0;
                    phase    = (hold_cfg == 0) ? RNG_SAMPLE : RNG_HOLD;
                end
            end
            RNG_HOLD: begin
                res.flags.drv_en = 1'b1;
                res.flags.busy   = 1'b1;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= hold_cfg) begin
                    tick_cnt = '0;
                    phase    = RNG_SAMPLE;
                end
            end
            RNG_SAMPLE: begin
                res.flags.busy = 1'b1;
                idx = tick_cnt[IDX_W-1:0];
                if (!echo && idx > mend_cfg) begin
                    res.flags.done = 1'b1;
                    quot = 0;
                    if (idx >= first_hi) begin
                        dur  = idx;
                        dur  = dur - first_hi;
                        quot = (dur << FRACTION_BITS_DEF) / DIVISOR_DEF;
                    end
                    finish_measurement((quot > DIST_MAX) ? DIST_MAX : quot[DIST_W-1:0], 1'b0);
                end else begin
                    if (echo && first_hi == 0)
                        first_hi = idx;
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= win_cfg) begin
                        res.flags.done = 1'b1;
                        tmo = 1'b1;
                        finish_measurement('0, 1'b1);
                    end
                end
            end
            RNG_SETTLE: begin
                res.flags.busy = 1'b1;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= settle_cfg) begin
                    tick_cnt = '0;
                    phase    = RNG_IDLE;
                end
            end
            default: begin
                phase    = RNG_IDLE;
                tick_cnt = '0;
            end
        endcase
        res.flags.tmo  = res.flags.done & last_tmo & tmo;
        res.distance   = last_dist;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_tick_result want;
        t_tick_result got;
        if (!i_rst_n) begin
            trig_cfg   = TRIGGER_RST;
            hold_cfg   = HOLDOFF_RST;
            win_cfg    = WINDOW_RST;
            mend_cfg   = MIN_END_RST;
            settle_cfg = SETTLE_RST;
            phase      = RNG_IDLE;
            tick_cnt   = '0;
            first_hi   = '0;
            last_dist  = '0;
            last_tmo   = 1'b0;
            results_due.delete();
            o_fail_count    = 0;
            o_pending       = 0;
            o_done_count    = 0;
            o_timeout_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TRIGGER: trig_cfg   = i_cfg_wdata[7:0];
                    CFG_HOLDOFF: hold_cfg   = i_cfg_wdata[15:0];
                    CFG_WINDOW:  win_cfg    = i_cfg_wdata[IDX_W-1:0];
                    CFG_MIN_END: mend_cfg   = i_cfg_wdata[IDX_W-1:0];
                    CFG_SETTLE:  settle_cfg = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tdata[0], i_s_tdata[1], want);
                results_due.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    $error("result request with no tick outstanding: %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    got  = i_m_tdata[18:0];
                    check_field("pin_drive_enable", want.flags.drv_en, got.flags.drv_en);
                    check_field("pin_drive_level", want.flags.drv_lvl, got.flags.drv_lvl);
                    check_field("busy_res", want.flags.busy, got.flags.busy);
                    check_field("done_res", want.flags.done, got.flags.done);
                    check_field("timed_out", want.flags.tmo, got.flags.tmo);
                    check_field("distance_cm_q4", want.distance, got.distance);
                    check_field("tdata padding", 0, i_m_tdata[23:19]);
                    if (want.flags.done)
                        o_done_count++;
                    if (want.flags.tmo)
                        o_timeout_count++;
                end
            end
            o_pending = results_due.size();
        end
    end

endmodule

/* tb/tb_ultrasonic_ping_ranger_core.sv */
// Testbench top for ultrasonic_ping_ranger_core: drives echo ticks and register writes,
// stalls both streams, gives the verdict. Needs upr_pkg, the core and upr_tick_checker.
`timescale 1ns / 1ps

module tb_ultrasonic_ping_ranger_core;
    import upr_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_TICKS = 600;
    localparam int DRAIN_CYCLES = 16;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [23:0]       m_tdata;

    logic steady = 1'b0;
    int   fail_count;
    int   pending;
    int   done_count;
    int   timeout_count;
    int   cycle_count = 0;
    int   ticks_sent  = 0;
    int   settings    = 0;
    int   cur_trig    = TRIGGER_RST;
    int   cur_hold    = HOLDOFF_RST;
    int   cur_win     = WINDOW_RST;
    int   cur_mend    = MIN_END_RST;
    int   cur_settle  = SETTLE_RST;

    ultrasonic_ping_ranger_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    upr_tick_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_done_count    (done_count),
        .o_timeout_count (timeout_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one tick request; called and returns at a falling edge
    task automatic send_tick(input bit start, input bit echo);
        if (!steady && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, echo, start};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_config(input int trig, input int hold, input int win, input int mend,
                              input int settle);
        drain();
        cur_trig   = trig;
        cur_hold   = hold;
        cur_win    = win;
        cur_mend   = mend;
        cur_settle = settle;
        settings++;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TRIGGER;
        i_cfg_wdata <= CFG_W'(trig);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_HOLDOFF;
        i_cfg_wdata <= CFG_W'(hold);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_WINDOW;
        i_cfg_wdata <= CFG_W'(win);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_MIN_END;
        i_cfg_wdata <= CFG_W'(mend);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SETTLE;
        i_cfg_wdata <= CFG_W'(settle);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pre_sample_ticks();
        return ((cur_trig == 0) ? 1 : cur_trig) - 1 + cur_hold;
    endfunction

    // start, trigger and hold-off, then lows, a high pulse and a low tail
    task automatic echo_run(input int l0, input int hi, input int lo, input bit busy_starts);
        send_tick(1'b1, 1'($urandom_range(1)));
        repeat (pre_sample_ticks())
            send_tick(busy_starts || ($urandom_range(9) == 0), 1'($urandom_range(1)));
        repeat (l0) send_tick(1'b0, 1'b0);
        repeat (hi) send_tick(1'b0, 1'b1);
        repeat (lo) send_tick(1'b0, 1'b0);
    endtask

    // echo samples taken from a bit pattern, lowest bit first
    task automatic pattern_run(input logic [31:0] pat, input int n, input int tail);
        send_tick(1'b1, 1'b0);
        repeat (pre_sample_ticks()) send_tick(1'b1, 1'($urandom_range(1)));
        for (int i = 0; i < n; i++)
            send_tick(1'b0, pat[i]);
        repeat (tail) send_tick(1'b0, 1'b0);
    endtask

    task automatic random_measurement();
        int l0;
        int hi;
        int lo;
        if ($urandom_range(4) == 0) begin
            // broken sequence: random starts and echo throughout
            send_tick(1'b1, 1'($urandom_range(1)));
            repeat ($urandom_range(1, pre_sample_ticks() + cur_win + cur_settle + 4))
                send_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
        end else begin
            l0 = $urandom_range(0, cur_mend + 2);
            hi = $urandom_range(0, cur_win);
            lo = ((l0 + hi <= cur_mend) ? cur_mend + 1 - (l0 + hi) : 1) + cur_settle
                 + $urandom_range(0, 2);
            echo_run(l0, hi, lo, 1'b0);
        end
    endtask

    initial begin : stimulus
        int base;
        int phase_no;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 60-tick echo pulse, settle cut short by the next settings
        echo_run(50, 60, 20, 1'b0);

        // zero trigger, hold-off and settle; high at index 0 overwritten later
        set_config(0, 0, 6, 1, 0);
        send_tick(1'b0, 1'b0);
        pattern_run(32'h5, 4, 2);
        // window expiry with starts while busy
        set_config(1, 3, 8, 2, 2);
        pattern_run(32'hFFFF, 10, 4);
        // zero window
        set_config(2, 1, 0, 0, 1);
        pattern_run(32'h1, 1, 3);
        // no high sample at all
        set_config(1, 0, 10, 3, 0);
        pattern_run(32'h0, 6, 2);
        set_config(3, 2, 40, 5, 3);
        pattern_run(32'h0FFF_FFF0, 30, 5);

        base     = ticks_sent;
        phase_no = 0;
        while (ticks_sent - base < RANDOM_TICKS) begin
            set_config(($urandom_range(15) == 0) ? 255 : $urandom_range(0, 8),
                       $urandom_range(0, 12), $urandom_range(0, 60),
                       $urandom_range(0, 30), $urandom_range(0, 16));
            steady <= (phase_no == 2);
            repeat ($urandom_range(3, 6)) random_measurement();
            phase_no++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d ticks over %0d register settings", ticks_sent, settings + 1);
        $display("%0d measurements finished, %0d of them by window timeout",
                 done_count, timeout_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/upr_pkg.sv
rtl/upr_dist_scale.sv
rtl/ultrasonic_ping_ranger_core.sv
tb/upr_tick_checker.sv
tb/tb_ultrasonic_ping_ranger_core.sv
